>>> rtl/core/assert_macros.svh
// Assertion macros shared by the RTL in this folder.
// No dependencies; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("%m: invariant violated");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

>>> rtl/core/blr_pkg.sv
// Package for the line rasterizer: request and response payload types,
// the opcode encoding and the framebuffer row shift. No dependencies.
package blr_pkg;

   // Framebuffer row pitch as a power of two, in bytes.
   localparam int unsigned ROW_SHIFT = 10;

   localparam int unsigned ADDR_WIDTH   = 32;
   localparam int unsigned COORD_WIDTH  = 9;
   localparam int unsigned ROW_WIDTH    = 8;
   localparam int unsigned COLOUR_WIDTH = 16;

   typedef enum logic {
      OP_START = 1'b0,
      OP_STEP  = 1'b1
   } opcode_type;

   typedef struct packed {
      opcode_type              opcode;
      logic [COORD_WIDTH-1:0]  start_x;
      logic [ROW_WIDTH-1:0]    start_y;
      logic [COORD_WIDTH-1:0]  end_x;
      logic [ROW_WIDTH-1:0]    end_y;
      logic [COLOUR_WIDTH-1:0] colour;
   } req_payload_type;

   typedef struct packed {
      logic [COORD_WIDTH-1:0]  pixel_x;
      logic [ROW_WIDTH-1:0]    pixel_y;
      logic [ADDR_WIDTH-1:0]   pixel_address;
      logic [COLOUR_WIDTH-1:0] pixel_colour;
      logic                    last_pixel;
   } rsp_payload_type;

endpackage

>>> rtl/core/bresenham_line_rasterizer.sv
// Bresenham line rasterizer: rsp_valid rises in the cycle after an accepted step request.
// Throughput is one request per cycle unless rsp_ready stalls; line state updates on accept.
// A start request gives no response; a step request while idle gives none either.
// Reset (synchronous, active high) clears busy, the output register valid and buffer_base.
// Depends on blr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bresenham_line_rasterizer (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  blr_pkg::req_payload_type         req_payload,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output blr_pkg::rsp_payload_type         rsp_payload,
   input  logic                             csr_write_enable,
   input  logic [blr_pkg::ADDR_WIDTH-1:0]   csr_write_data
);

   localparam int unsigned CW = blr_pkg::COORD_WIDTH;
   localparam int unsigned RW = blr_pkg::ROW_WIDTH;
   localparam int unsigned AW = blr_pkg::ADDR_WIDTH;
   localparam int unsigned EW = CW + 1;   // error term: signed, one bit above the span

   // ------------------------------------------------------------------
   // Registers. Only control state is reset: the line geometry is always
   // loaded by a start request before busy can be set.
   // ------------------------------------------------------------------
   logic [AW-1:0]         buffer_base_ff, buffer_base_in;
   logic                  busy_ff, busy_in;
   logic                  is_vertical_ff, is_vertical_in;
   logic                  is_steep_ff, is_steep_in;
   logic [CW-1:0]         major_pos_ff, major_pos_in;
   logic [CW-1:0]         major_end_ff, major_end_in;
   logic [CW-1:0]         minor_pos_ff, minor_pos_in;
   logic                  minor_neg_ff, minor_neg_in;
   logic [CW-1:0]         major_span_ff, major_span_in;
   logic [CW-1:0]         minor_span_ff, minor_span_in;
   logic signed [EW-1:0]  error_term_ff, error_term_in;
   logic [blr_pkg::COLOUR_WIDTH-1:0] line_colour_ff, line_colour_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   blr_pkg::rsp_payload_type rsp_payload_ff, rsp_payload_in;

   // The output register frees up in the same cycle it is drained, so a new
   // request can enter while the previous response is being taken.
   logic req_fire;
   logic is_start;
   logic rsp_load;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign is_start  = req_fire && (req_payload.opcode == blr_pkg::OP_START);
   assign rsp_load  = req_fire && (req_payload.opcode == blr_pkg::OP_STEP) && busy_ff;

   // ------------------------------------------------------------------
   // Line setup for a start request. A line with equal x is vertical and
   // runs from the smaller y. Otherwise the major axis is the longer one,
   // endpoints are ordered by the major coordinate, and the error term
   // starts at half the major span.
   // ------------------------------------------------------------------
   logic [CW-1:0] sx, ex, sy, ey;
   logic [CW-1:0] dx, dy;
   logic          ld_vertical, ld_steep, ld_swap;
   logic [CW-1:0] a0, a1, b0, b1;
   logic [CW-1:0] ld_major_pos, ld_major_end, ld_minor_pos;
   logic [CW-1:0] ld_major_span, ld_minor_span;
   logic          ld_minor_neg;
   logic signed [EW-1:0] ld_error;

   always_comb begin
      sx = req_payload.start_x;
      ex = req_payload.end_x;
      sy = CW'(req_payload.start_y);
      ey = CW'(req_payload.end_y);
      dx = (ex > sx) ? (ex - sx) : (sx - ex);
      dy = (ey > sy) ? (ey - sy) : (sy - ey);
      ld_vertical = (sx == ex);
      ld_steep    = !ld_vertical && (dy > dx);

      if (ld_vertical || ld_steep) begin
         a0 = sy; a1 = ey; b0 = sx; b1 = ex;
      end else begin
         a0 = sx; a1 = ex; b0 = sy; b1 = ey;
      end
      ld_swap = (a1 < a0);

      ld_major_pos  = ld_swap ? a1 : a0;
      ld_major_end  = ld_swap ? a0 : a1;
      ld_minor_pos  = ld_swap ? b1 : b0;
      ld_major_span = ld_major_end - ld_major_pos;
      ld_minor_span = ld_vertical ? '0 : ((b1 > b0) ? (b1 - b0) : (b0 - b1));
      // After the swap the minor coordinate heads toward the other endpoint.
      ld_minor_neg  = !ld_vertical && (ld_swap ? (b0 < b1) : (b1 < b0));
      ld_error      = ld_vertical ? '0 : EW'(ld_major_span >> 1);
   end

   // ------------------------------------------------------------------
   // Pixel for a step request: one Bresenham update. The minor span is
   // subtracted; on a negative result the minor coordinate moves one step
   // and the major span is added back, which keeps the term non-negative.
   // ------------------------------------------------------------------
   logic [CW-1:0]        px, py;
   logic                 st_last;
   logic signed [EW-1:0] err_sub;
   logic                 minor_move;
   logic [AW-1:0]        pix_addr;

   always_comb begin
      if (is_vertical_ff || is_steep_ff) begin
         px = minor_pos_ff;
         py = major_pos_ff;
      end else begin
         px = major_pos_ff;
         py = minor_pos_ff;
      end
      st_last    = (major_pos_ff == major_end_ff);
      err_sub    = error_term_ff - $signed(EW'(minor_span_ff));
      minor_move = !is_vertical_ff && err_sub[EW-1];
      pix_addr   = buffer_base_ff + (AW'(py) << blr_pkg::ROW_SHIFT) + (AW'(px) << 1);
   end

   // ------------------------------------------------------------------
   // Next-state logic.
   // ------------------------------------------------------------------
   always_comb begin
      buffer_base_in = csr_write_enable ? csr_write_data : buffer_base_ff;
      busy_in        = busy_ff;
      is_vertical_in = is_vertical_ff;
      is_steep_in    = is_steep_ff;
      major_pos_in   = major_pos_ff;
      major_end_in   = major_end_ff;
      minor_pos_in   = minor_pos_ff;
      minor_neg_in   = minor_neg_ff;
      major_span_in  = major_span_ff;
      minor_span_in  = minor_span_ff;
      error_term_in  = error_term_ff;
      line_colour_in = line_colour_ff;

      if (is_start) begin
         // A start always wins, dropping any line still in progress.
         busy_in        = 1'b1;
         is_vertical_in = ld_vertical;
         is_steep_in    = ld_steep;
         major_pos_in   = ld_major_pos;
         major_end_in   = ld_major_end;
         minor_pos_in   = ld_minor_pos;
         minor_neg_in   = ld_minor_neg;
         major_span_in  = ld_major_span;
         minor_span_in  = ld_minor_span;
         error_term_in  = ld_error;
         line_colour_in = req_payload.colour;
      end else if (rsp_load) begin
         if (st_last) begin
            busy_in = 1'b0;
         end else begin
            major_pos_in = major_pos_ff + 1'b1;
            if (!is_vertical_ff) begin
               if (minor_move) begin
                  minor_pos_in  = minor_neg_ff ? (minor_pos_ff - 1'b1)
                                               : (minor_pos_ff + 1'b1);
                  error_term_in = err_sub + $signed(EW'(major_span_ff));
               end else begin
                  error_term_in = err_sub;
               end
            end
         end
      end

      // Output register: load on a step to an active line, otherwise hold until drained.
      rsp_payload_in = rsp_payload_ff;
      if (rsp_load) begin
         rsp_valid_in                 = 1'b1;
         rsp_payload_in.pixel_x       = px;
         rsp_payload_in.pixel_y       = py[RW-1:0];
         rsp_payload_in.pixel_address = pix_addr;
         rsp_payload_in.pixel_colour  = line_colour_ff;
         rsp_payload_in.last_pixel    = st_last;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buffer_base_ff <= '0;
         busy_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         buffer_base_ff <= buffer_base_in;
         busy_ff        <= busy_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      is_vertical_ff <= is_vertical_in;
      is_steep_ff    <= is_steep_in;
      major_pos_ff   <= major_pos_in;
      major_end_ff   <= major_end_in;
      minor_pos_ff   <= minor_pos_in;
      minor_neg_ff   <= minor_neg_in;
      major_span_ff  <= major_span_in;
      minor_span_ff  <= minor_span_in;
      error_term_ff  <= error_term_in;
      line_colour_ff <= line_colour_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // ------------------------------------------------------------------
   // Checks.
   // ------------------------------------------------------------------
   `ASSERT_NEXT(a_step_gives_response, clock, reset, rsp_load, rsp_valid_ff)
   `ASSERT_NEXT(a_start_sets_busy, clock, reset, is_start, busy_ff)
   `ASSERT_NEXT(a_last_clears_busy, clock, reset, rsp_load && st_last && !is_start, !busy_ff)
   `ASSERT_ALWAYS(a_error_nonneg, clock, reset, !busy_ff || !error_term_ff[EW-1])
   `ASSERT_ALWAYS(a_vertical_no_error, clock, reset,
                  !(busy_ff && is_vertical_ff) || (error_term_ff == '0))

endmodule

>>> tb/bresenham_line_rasterizer_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the Bresenham line rasterizer: directed lines, then random lines.
// Depends on blr_pkg and the bresenham_line_rasterizer RTL; reads no files.

module bresenham_line_rasterizer_tb;

   localparam int CYCLE_LIMIT = 500000;
   localparam int COORD_BITS  = blr_pkg::COORD_WIDTH;
   localparam int ROW_BITS    = blr_pkg::ROW_WIDTH;
   localparam int COLOUR_BITS = blr_pkg::COLOUR_WIDTH;
   localparam int ADDR_BITS   = blr_pkg::ADDR_WIDTH;

   // Every input of the block has a known value from time zero.
   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   blr_pkg::req_payload_type req_payload = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b1;
   blr_pkg::rsp_payload_type rsp_payload;
   logic                     csr_write_enable = 1'b0;
   logic [ADDR_BITS-1:0]     csr_write_data = '0;

   // Shared run state. When idling_on is clear, neither side inserts gaps.
   bit                       idling_on = 1'b0;
   int                       mismatch_count = 0;
   int                       requests_counted = 0;
   int                       cycle_count = 0;
   int                       stall_left = 0;
   blr_pkg::rsp_payload_type pending_pixels[$];

   // Our own copy of the line state, updated as each request is accepted.
   logic                    line_busy = 1'b0;
   logic                    line_vertical = 1'b0;
   logic                    line_steep = 1'b0;
   logic                    minor_down = 1'b0;
   logic [COORD_BITS-1:0]   major_at = '0;
   logic [COORD_BITS-1:0]   major_stop = '0;
   logic [COORD_BITS-1:0]   minor_at = '0;
   logic [COORD_BITS-1:0]   major_len = '0;
   logic [COORD_BITS-1:0]   minor_len = '0;
   int                      error_acc = 0;
   logic [COLOUR_BITS-1:0]  line_colour = '0;
   logic [ADDR_BITS-1:0]    buffer_base_q = '0;

   bresenham_line_rasterizer DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Applies one accepted request to the line state. A step while a line is
   // active yields the pixel the block must return, queued in request order.
   task automatic rasterize_request(input blr_pkg::req_payload_type item);
      logic [COORD_BITS-1:0]    sx, sy, ex, ey, dx, dy, a0, a1, b0, b1, px, py;
      blr_pkg::rsp_payload_type pix;
      if (item.opcode == blr_pkg::OP_START) begin
         sx = item.start_x;
         sy = {1'b0, item.start_y};
         ex = item.end_x;
         ey = {1'b0, item.end_y};
         line_colour = item.colour;
         line_busy = 1'b1;
         if (sx == ex) begin
            // Vertical lines, single points among them, always run downward in y.
            line_vertical = 1'b1;
            line_steep = 1'b0;
            major_at = (sy < ey) ? sy : ey;
            major_stop = (sy < ey) ? ey : sy;
            minor_at = sx;
            minor_down = 1'b0;
            major_len = major_stop - major_at;
            minor_len = '0;
            error_acc = 0;
         end else begin
            dx = (ex > sx) ? ex - sx : sx - ex;
            dy = (ey > sy) ? ey - sy : sy - ey;
            line_vertical = 1'b0;
            line_steep = dy > dx;
            if (line_steep) begin
               a0 = sy; a1 = ey; b0 = sx; b1 = ex;
            end else begin
               a0 = sx; a1 = ex; b0 = sy; b1 = ey;
            end
            // Always walk the major axis from the smaller coordinate upward.
            if (a1 < a0) begin
               {a0, a1} = {a1, a0};
               {b0, b1} = {b1, b0};
            end
            major_at = a0;
            major_stop = a1;
            minor_at = b0;
            minor_down = b1 < b0;
            major_len = a1 - a0;
            minor_len = minor_down ? b0 - b1 : b1 - b0;
            error_acc = int'(major_len) / 2;
         end
      end else if (line_busy) begin
         if (line_vertical || line_steep) begin
            px = minor_at;
            py = major_at;
         end else begin
            px = major_at;
            py = minor_at;
         end
         pix.pixel_x = px;
         pix.pixel_y = py[ROW_BITS-1:0];
         pix.pixel_address = buffer_base_q + (32'(py) << blr_pkg::ROW_SHIFT)
                             + (32'(px) << 1);
         pix.pixel_colour = line_colour;
         pix.last_pixel = (major_at == major_stop);
         pending_pixels.push_back(pix);
         if (pix.last_pixel) begin
            line_busy = 1'b0;
         end else begin
            major_at = major_at + 1'b1;
            if (!line_vertical) begin
               error_acc -= int'(minor_len);
               if (error_acc < 0) begin
                  minor_at = minor_down ? minor_at - 1'b1 : minor_at + 1'b1;
                  error_acc += int'(major_len);
               end
            end
         end
      end
   endtask

   // Drives one request and holds it until the block takes it. Called just
   // after a rising edge; valid is only lowered when a gap is inserted.
   task automatic send_request(input blr_pkg::req_payload_type item);
      if (idling_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
      // Steps that find no active line are ignored by the block and not counted.
      if (item.opcode == blr_pkg::OP_START || line_busy) requests_counted++;
      rasterize_request(item);
   endtask

   function automatic blr_pkg::req_payload_type line_request(input int sx, input int sy,
                                                             input int ex, input int ey,
                                                             input int colour);
      blr_pkg::req_payload_type item;
      item.opcode = blr_pkg::OP_START;
      item.start_x = COORD_BITS'(sx);
      item.start_y = ROW_BITS'(sy);
      item.end_x = COORD_BITS'(ex);
      item.end_y = ROW_BITS'(ey);
      item.colour = COLOUR_BITS'(colour);
      return item;
   endfunction

   // Step requests carry random junk in the fields the block must ignore.
   function automatic blr_pkg::req_payload_type step_request();
      blr_pkg::req_payload_type item;
      item = line_request($urandom_range(0, 511), $urandom_range(0, 255),
                          $urandom_range(0, 511), $urandom_range(0, 255), $urandom);
      item.opcode = blr_pkg::OP_STEP;
      return item;
   endfunction

   task automatic send_steps(input int count);
      repeat (count) send_request(step_request());
   endtask

   // The register may only change while nothing is in flight, so drain the
   // pending pixels and let the output register settle before writing.
   task automatic write_buffer_base(input logic [ADDR_BITS-1:0] value);
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      buffer_base_q = value;
      csr_write_enable <= 1'b0;
   endtask

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, field, got, want);
   endtask

   // Response checker. Values are read right after the edge, before the
   // block's own updates land, so they are the ones the edge accepted.
   always @(posedge clock) begin
      blr_pkg::rsp_payload_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_pixels.size() == 0) begin
            report_mismatch("unrequested pixel address", rsp_payload.pixel_address, '0);
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_payload.pixel_x !== want.pixel_x)
               report_mismatch("pixel_x", 32'(rsp_payload.pixel_x), 32'(want.pixel_x));
            if (rsp_payload.pixel_y !== want.pixel_y)
               report_mismatch("pixel_y", 32'(rsp_payload.pixel_y), 32'(want.pixel_y));
            if (rsp_payload.pixel_address !== want.pixel_address)
               report_mismatch("pixel_address", rsp_payload.pixel_address,
                               want.pixel_address);
            if (rsp_payload.pixel_colour !== want.pixel_colour)
               report_mismatch("pixel_colour", 32'(rsp_payload.pixel_colour),
                               32'(want.pixel_colour));
            if (rsp_payload.last_pixel !== want.last_pixel)
               report_mismatch("last_pixel", 32'(rsp_payload.last_pixel),
                               32'(want.last_pixel));
         end
      end
   end

   // Response back-pressure: random stalls while idling is on.
   always @(posedge clock) begin
      if (stall_left > 0) stall_left--;
      else if (idling_on && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 6);
      rsp_ready <= (stall_left == 0);
   end

   // Watchdog: a hung handshake or a missing pixel ends the run here.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("*** FAILED ***");
      $finish;
   end

   // Steps with no line loaded, right after reset, must be ignored.
   task automatic test_idle_steps();
      send_steps(2);
   endtask

   // A single point; the second step finds the line done.
   task automatic test_single_point();
      send_request(line_request(319, 239, 319, 239, 16'hFFFF));
      send_steps(2);
   endtask

   // A vertical line given bottom to top must still be drawn top to bottom.
   task automatic test_vertical_line();
      send_request(line_request(0, 3, 0, 0, 16'h0000));
      send_steps(4);
   endtask

   // A new start while a long line is in progress drops the old line at once.
   task automatic test_dropped_line();
      send_request(line_request(511, 255, 0, 0, 16'hA5A5));
      send_steps(2);
      send_request(line_request(2, 0, 5, 2, 16'h5A5A));
      send_steps(4);
   endtask

   // A steep line drawn right to left with its endpoints given top first.
   task automatic test_steep_line();
      send_request(line_request(10, 0, 8, 5, 16'h07E0));
      send_steps(6);
   endtask

   // With the base near the top of the address space the address must wrap.
   task automatic test_address_wrap();
      write_buffer_base(32'hFFFF_FF00);
      send_request(line_request(319, 239, 318, 239, 16'hF800));
      send_steps(2);
   endtask

   function automatic int near_coord(input int centre, input int reach, input int top);
      int value;
      value = centre + $urandom_range(0, 2 * reach) - reach;
      if (value < 0) value = 0;
      if (value > top) value = top;
      return value;
   endfunction

   // Random lines, mostly drawn to completion. A few are abandoned part way,
   // and some plain steps land wherever the line state happens to be.
   task automatic draw_random_lines(input int budget);
      int target, kind, reach, sx, sy, ex, ey;
      target = requests_counted + budget;
      while (requests_counted < target) begin
         kind = $urandom_range(0, 19);
         if (kind == 0) begin
            send_steps(1);
         end else if (kind <= 2) begin
            send_request(line_request($urandom_range(0, 511), $urandom_range(0, 255),
                                      $urandom_range(0, 511), $urandom_range(0, 255),
                                      $urandom));
            send_steps($urandom_range(0, 40));
         end else begin
            reach = ($urandom_range(0, 15) == 0) ? 511 : 12;
            sx = $urandom_range(0, 511);
            sy = $urandom_range(0, 255);
            ex = near_coord(sx, reach, 511);
            ey = near_coord(sy, reach, 255);
            // Bias some lines to the vertical, horizontal and diagonal shapes.
            case ($urandom_range(0, 7))
               0: ex = sx;
               1: ey = sy;
               2: if (sy + (ex - sx) >= 0 && sy + (ex - sx) <= 255) ey = sy + (ex - sx);
               default: ;
            endcase
            send_request(line_request(sx, sy, ex, ey, $urandom));
            while (line_busy) send_steps(1);
            if ($urandom_range(0, 3) == 0) send_steps(1);
         end
      end
   endtask

   // Several base settings, extremes included. The last two stretches run
   // with no gaps on either side, so the block is held at full rate.
   task automatic test_random_lines();
      write_buffer_base($urandom);
      draw_random_lines(600);
      write_buffer_base(32'hFFFF_FFFF);
      draw_random_lines(500);
      idling_on = 1'b0;
      write_buffer_base(32'h0000_0000);
      draw_random_lines(300);
      write_buffer_base($urandom);
      draw_random_lines(550);
   endtask

   // Wait for every pixel still owed, then for the block to go quiet.
   task automatic finish_run();
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      idling_on = 1'b1;
      test_idle_steps();
      test_single_point();
      test_vertical_line();
      test_dropped_line();
      test_steep_line();
      test_address_wrap();
      test_random_lines();
      finish_run();
   end

endmodule
